@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, quiet while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/mdexp_pkg.sv @@
package mdexp_pkg;

   // width of base, modulus and result
   localparam int OPERAND_W = 30;
   // width of the exponent field on the request beat
   localparam int EXP_FIELD_W = 32;
   // iteration counter of the modular multiplier
   localparam int MUL_CNT_W = $clog2(OPERAND_W);

   localparam logic [OPERAND_W-1:0] MOD_RESET = OPERAND_W'(1000000007);
   localparam logic [OPERAND_W-1:0] ONE_VALUE = OPERAND_W'(1);

   // register indexes
   localparam logic REG_MODULUS = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SQUARE,
      ST_MULT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [OPERAND_W-1:0] multiplicand;
      logic [OPERAND_W-1:0] multiplier;
   } mul_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [OPERAND_W-1:0] product;
   } mul_rsp_type;

endpackage

@@ rtl/modular_exponentiation_core.sv @@
// modular exponentiation core: each request beat carries a base and an exponent and
// produces one response beat holding base^exponent mod modulus, computed by left-to-right
// square-and-multiply on one shared interleaved modular multiplier. the modulus sits in
// the apb register at byte address 0 (reset value 1000000007) and may be changed only
// while the core is idle. a zero exponent gives 1, and a modulus of 0 or 1 gives 0 for any
// other exponent. otherwise leading zero exponent bits are skipped without a multiply; a
// square, or the first product that brings in the base, takes the 30 multiplier-bit steps
// of the shared unit plus issue and collect, and a multiply by the base is issued on the
// cycle its square comes back. req_tready is high only while idle; a finished response
// waits in its output register while the next request is taken.
module modular_exponentiation_core #(
   parameter int EXP_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [29:0] base_value, [61:30] exponent, [63:62] zero
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [29:0] power_result, [31:30] zero
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "assert_macros.svh"

   localparam int W      = mdexp_pkg::OPERAND_W;
   localparam int EXP_FW = mdexp_pkg::EXP_FIELD_W;
   // only the low EXP_WIDTH exponent bits count
   localparam int EFF_W  = (EXP_WIDTH < EXP_FW) ? EXP_WIDTH : EXP_FW;
   localparam int BCNT_W = $clog2(EFF_W + 1);

   // ---------------- configuration register ----------------
   logic [W-1:0] modulus_ff, modulus_in;
   logic         csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_wr && (csr_paddr[2] == mdexp_pkg::REG_MODULUS)) begin
         modulus_in = csr_pwdata[W-1:0];
      end
   end

   // read data, word index decoded from the upper address bit
   always_comb begin
      unique case (csr_paddr[2])
         mdexp_pkg::REG_MODULUS: csr_prdata = {{(32 - W){1'b0}}, modulus_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // ---------------- request fields ----------------
   logic [W-1:0]      req_base;
   logic [EXP_FW-1:0] req_exp_full;
   logic [EFF_W-1:0]  req_exp;

   assign req_base     = req_tdata[W-1:0];
   assign req_exp_full = req_tdata[W+EXP_FW-1:W];
   assign req_exp      = req_exp_full[EFF_W-1:0];

   // ---------------- sequencer state and datapath ----------------
   mdexp_pkg::state_type state_ff, state_in;

   logic [W-1:0]      base_ff, base_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic [EFF_W-1:0]  exp_ff, exp_in;
   logic [BCNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic              started_ff, started_in;
   logic [W-1:0]      res_ff, res_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [W-1:0]      rsp_data_ff, rsp_data_in;

   mdexp_pkg::mul_req_type mul_req;
   mdexp_pkg::mul_rsp_type mul_rsp;

   logic req_beat;
   logic exp_zero;
   logic mod_degenerate;
   logic exp_msb;
   logic out_free;

   assign req_beat       = req_tvalid && req_tready;
   assign exp_zero       = (req_exp == '0);
   // modulus of 0 or 1 reduces everything to 0
   assign mod_degenerate = (modulus_ff[W-1:1] == '0);
   assign exp_msb        = exp_ff[EFF_W-1];
   assign out_free       = !rsp_tvalid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mdexp_pkg::ST_IDLE: begin
            if (req_beat) begin
               state_in = (exp_zero || mod_degenerate) ? mdexp_pkg::ST_DONE
                                                       : mdexp_pkg::ST_SCAN;
            end
         end
         mdexp_pkg::ST_SCAN: begin
            if (bit_cnt_ff == '0) begin
               state_in = mdexp_pkg::ST_DONE;
            end else if (started_ff) begin
               state_in = mdexp_pkg::ST_SQUARE;
            end else if (exp_msb) begin
               state_in = mdexp_pkg::ST_MULT;
            end
         end
         mdexp_pkg::ST_SQUARE: begin
            if (mul_rsp.done) begin
               state_in = exp_msb ? mdexp_pkg::ST_MULT : mdexp_pkg::ST_SCAN;
            end
         end
         mdexp_pkg::ST_MULT: begin
            if (mul_rsp.done) begin
               state_in = mdexp_pkg::ST_SCAN;
            end
         end
         mdexp_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = mdexp_pkg::ST_IDLE;
            end
         end
         default: state_in = mdexp_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and multiplier issue
   always_comb begin
      req_tready           = 1'b0;
      mul_req.start        = 1'b0;
      mul_req.multiplicand = acc_ff;
      mul_req.multiplier   = base_ff;
      unique case (state_ff)
         mdexp_pkg::ST_IDLE: req_tready = 1'b1;
         mdexp_pkg::ST_SCAN: begin
            if (bit_cnt_ff != '0) begin
               if (started_ff) begin
                  // square the accumulator
                  mul_req.start      = 1'b1;
                  mul_req.multiplier = acc_ff;
               end else if (exp_msb) begin
                  // first set bit: accumulator is 1, this also reduces the base
                  mul_req.start = 1'b1;
               end
            end
         end
         mdexp_pkg::ST_SQUARE: begin
            if (mul_rsp.done && exp_msb) begin
               mul_req.start        = 1'b1;
               mul_req.multiplicand = mul_rsp.product;
            end
         end
         mdexp_pkg::ST_MULT: ;
         mdexp_pkg::ST_DONE: ;
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      base_in       = base_ff;
      acc_in        = acc_ff;
      exp_in        = exp_ff;
      bit_cnt_in    = bit_cnt_ff;
      started_in    = started_ff;
      res_in        = res_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         mdexp_pkg::ST_IDLE: begin
            if (req_beat) begin
               base_in    = req_base;
               acc_in     = mdexp_pkg::ONE_VALUE;
               exp_in     = req_exp;
               bit_cnt_in = BCNT_W'(EFF_W);
               started_in = 1'b0;
               // zero exponent wins over a degenerate modulus
               res_in     = exp_zero ? mdexp_pkg::ONE_VALUE : '0;
            end
         end
         mdexp_pkg::ST_SCAN: begin
            if (bit_cnt_ff == '0) begin
               res_in = acc_ff;
            end else if (!started_ff) begin
               if (exp_msb) begin
                  started_in = 1'b1;
               end else begin
                  // leading zero: skip without touching the accumulator
                  exp_in     = exp_ff << 1;
                  bit_cnt_in = bit_cnt_ff - 1'b1;
               end
            end
         end
         mdexp_pkg::ST_SQUARE: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.product;
               if (!exp_msb) begin
                  exp_in     = exp_ff << 1;
                  bit_cnt_in = bit_cnt_ff - 1'b1;
               end
            end
         end
         mdexp_pkg::ST_MULT: begin
            if (mul_rsp.done) begin
               acc_in     = mul_rsp.product;
               exp_in     = exp_ff << 1;
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         mdexp_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mdexp_pkg::ST_IDLE;
         modulus_ff    <= mdexp_pkg::MOD_RESET;
         rsp_tvalid_ff <= 1'b0;
         started_ff    <= 1'b0;
         bit_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         modulus_ff    <= modulus_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         started_ff    <= started_in;
         bit_cnt_ff    <= bit_cnt_in;
      end
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      exp_ff      <= exp_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // shared modular multiplier
   mdexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(32 - W){1'b0}}, rsp_data_ff};

   // ---------------- assertions ----------------
   logic mul_wait;
   logic scan_dry;

   // states that wait for a product
   assign mul_wait = (state_ff == mdexp_pkg::ST_SQUARE) || (state_ff == mdexp_pkg::ST_MULT);
   // scanning for the first set bit with no bits left
   assign scan_dry = (state_ff == mdexp_pkg::ST_SCAN) && !started_ff && (bit_cnt_ff == '0);

   // a new beat is never taken while the multiplier still works
   `ASSERT_CLK(a_ready_mul_idle, clock, reset, req_tready |-> !mul_rsp.busy, "ready while busy")
   // products come back only to the states that wait for them
   `ASSERT_CLK(a_done_expected, clock, reset, mul_rsp.done |-> mul_wait, "unexpected product")
   // before the first set bit there is always a bit left, the exponent being nonzero
   `ASSERT_NEVER(a_scan_bits_left, clock, reset, scan_dry, "exponent ran out before a set bit")
   // the multiplier is started only when free
   `ASSERT_NEVER(a_start_when_free, clock, reset, mul_req.start && mul_rsp.busy, "start while busy")

endmodule

@@ rtl/mdexp_mulmod.sv @@
// interleaved modular multiplier, one multiplier bit per cycle
module mdexp_mulmod (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [mdexp_pkg::OPERAND_W-1:0]        modulus,
   input  mdexp_pkg::mul_req_type                 mul_req,
   output mdexp_pkg::mul_rsp_type                 mul_rsp
);

   localparam int W = mdexp_pkg::OPERAND_W;
   localparam logic [mdexp_pkg::MUL_CNT_W-1:0] LAST_STEP = mdexp_pkg::MUL_CNT_W'(W - 1);

   logic [W-1:0]                      r_ff, r_in;
   logic [W-1:0]                      a_ff, a_in;
   logic [W-1:0]                      bits_ff, bits_in;
   logic [mdexp_pkg::MUL_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   logic [W+1:0] sum;
   logic [W+2:0] diff1;
   logic [W+2:0] diff2;
   logic [W-1:0] r_step;

   // 2r + bit*a stays below 3m, so at most 2m comes off
   always_comb begin
      sum   = {1'b0, r_ff, 1'b0} + {2'b00, (bits_ff[W-1] ? a_ff : '0)};
      diff1 = {1'b0, sum} - {3'b000, modulus};
      diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
      if (!diff2[W+2]) begin
         r_step = diff2[W-1:0];
      end else if (!diff1[W+2]) begin
         r_step = diff1[W-1:0];
      end else begin
         r_step = sum[W-1:0];
      end
   end

   always_comb begin
      r_in    = r_ff;
      a_in    = a_ff;
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start && !busy_ff) begin
         r_in    = '0;
         a_in    = mul_req.multiplicand;
         bits_in = mul_req.multiplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in    = r_step;
         bits_in = bits_ff << 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff    <= r_in;
      a_ff    <= a_in;
      bits_ff <= bits_in;
   end

   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = r_ff;

endmodule
